// File: hdl/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

	// Hue sector, one per 60 degrees of the wrapped hue
	typedef enum logic [2:0] {
		SECTOR_0,
		SECTOR_1,
		SECTOR_2,
		SECTOR_3,
		SECTOR_4,
		SECTOR_5
	} sector_t;

	// Multiple of 360 that lifts any 16-bit hue above zero
	localparam int unsigned HUE_OFFSET      = 33120;
	localparam int unsigned HUE_FULL        = 360;
	localparam int unsigned HUE_SECTOR      = 60;
	// Reciprocal of 360 scaled by 2^24, rounded up; exact below 65888
	localparam int unsigned HUE_RECIP       = 46604;
	localparam int unsigned HUE_RECIP_SHIFT = 24;
	// Full-scale channel factor, 256 * 60
	localparam int unsigned K_ONE           = 15360;
	localparam int unsigned CHAN_MAX        = 255;
	// Channel divisor 256 * 256 * 60 = 2^18 * 15
	localparam int unsigned CHAN_SHIFT      = 18;
	// Reciprocal of 15 scaled by 2^16, rounded up; exact below 3826
	localparam int unsigned DIV15_RECIP     = 4370;
	localparam int unsigned DIV15_SHIFT     = 16;

	// Classified request handed from the front part to the back part
	typedef struct packed {
		sector_t    sector;
		logic [5:0] rem;
		logic [8:0] sat;
		logic [8:0] val;
	} item_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Lowest hue of a sector
	function automatic logic [8:0] sector_base(sector_t sector);
		logic [8:0] base;
		case (sector)
			SECTOR_1: base = 9'd60;
			SECTOR_2: base = 9'd120;
			SECTOR_3: base = 9'd180;
			SECTOR_4: base = 9'd240;
			SECTOR_5: base = 9'd300;
			default:  base = 9'd0;
		endcase
		return base;
	endfunction

endpackage

`default_nettype wire

// File: hdl/hsvrgb_front.sv
`default_nettype none

module hsvrgb_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [15:0]        hue_degrees,
	input  logic signed [9:0]         saturation,
	input  logic signed [9:0]         brightness,
	input  hsvrgb_pkg::queue_status_t status,
	input  logic                      pop,
	output logic                      busy,
	output logic                      push,
	output hsvrgb_pkg::item_t         item
);
	import hsvrgb_pkg::*;

	logic        adv;
	logic [16:0] x_in;
	logic [32:0] prod;

	logic        vld_s1;
	logic [16:0] x_s1;
	logic [7:0]  quo_s1;
	logic [8:0]  sat_s1;
	logic [8:0]  val_s1;

	logic        vld_s2;
	logic [8:0]  hue_s2;
	logic [8:0]  sat_s2;
	logic [8:0]  val_s2;
	logic [16:0] hue_wide;

	logic        vld_s3;
	item_t       item_s3;
	sector_t     sector_c;

	// Clamp a signed Q2.8 value into 0..256
	function automatic logic [8:0] clamp_unit(logic [9:0] x);
		logic [8:0] res;
		if (x[9]) begin
			res = 9'd0;
		end else if (x[8:0] > 9'd256) begin
			res = 9'd256;
		end else begin
			res = x[8:0];
		end
		return res;
	endfunction

	// Hold the front only while the queue cannot take the last stage
	assign adv  = !(vld_s3 && status.full && !pop);
	assign busy = !adv;
	assign push = vld_s3 && adv;
	assign item = item_s3;

	// Lift the hue positive and estimate the quotient by 360
	always_comb begin
		x_in = 17'({hue_degrees[15], hue_degrees}) + 17'(HUE_OFFSET);
		prod = 33'(x_in) * 33'(HUE_RECIP);
	end

	// Remove whole turns
	assign hue_wide = x_s1 - 17'(quo_s1) * 17'(HUE_FULL);

	// Find the sector by threshold compare
	always_comb begin
		if (hue_s2 < 9'd60) begin
			sector_c = SECTOR_0;
		end else if (hue_s2 < 9'd120) begin
			sector_c = SECTOR_1;
		end else if (hue_s2 < 9'd180) begin
			sector_c = SECTOR_2;
		end else if (hue_s2 < 9'd240) begin
			sector_c = SECTOR_3;
		end else if (hue_s2 < 9'd300) begin
			sector_c = SECTOR_4;
		end else begin
			sector_c = SECTOR_5;
		end
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1           <= x_in;
			quo_s1         <= 8'(prod >> HUE_RECIP_SHIFT);
			sat_s1         <= clamp_unit(saturation);
			val_s1         <= clamp_unit(brightness);
			hue_s2         <= 9'(hue_wide);
			sat_s2         <= sat_s1;
			val_s2         <= val_s1;
			item_s3.sector <= sector_c;
			item_s3.rem    <= 6'(hue_s2 - sector_base(sector_c));
			item_s3.sat    <= sat_s2;
			item_s3.val    <= val_s2;
		end
	end

endmodule

`default_nettype wire

// File: hdl/hsvrgb_fifo.sv
`default_nettype none

module hsvrgb_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  hsvrgb_pkg::item_t         wr_item,
	input  logic                      pop,
	output hsvrgb_pkg::item_t         rd_item,
	output hsvrgb_pkg::queue_status_t status
);
	import hsvrgb_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + 1'b1;
		end
		return nxt;
	endfunction

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign rd_item      = mem_q[rd_ptr_q];

	// Track pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store a request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

`default_nettype wire

// File: hdl/hsvrgb_back.sv
`default_nettype none

module hsvrgb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  hsvrgb_pkg::queue_status_t status,
	input  hsvrgb_pkg::item_t         item,
	output logic                      pop,
	output logic                      done,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue
);
	import hsvrgb_pkg::*;

	logic [13:0] kv;
	logic [13:0] kp;
	logic [13:0] kq;
	logic [13:0] kt;
	logic [13:0] k_c [3];

	logic        vld_s1;
	logic [13:0] k_s1 [3];
	logic [8:0]  val_s1;

	logic        vld_s2;
	logic [21:0] m_s2 [3];

	logic        vld_s3;
	logic [11:0] y_s3 [3];

	logic        done_q;
	logic [7:0]  chan_q [3];

	// Drain the queue whenever it holds a request
	assign pop = !status.empty;

	// Form the channel factors of V, p, q and t
	always_comb begin
		kv = 14'(K_ONE);
		kp = 14'(14'(HUE_SECTOR) * 14'(9'd256 - item.sat));
		kq = 14'(K_ONE) - 14'(14'(item.sat) * 14'(item.rem));
		kt = 14'(K_ONE) - 14'(14'(item.sat) * 14'(6'(HUE_SECTOR) - item.rem));
	end

	// Arrange the factors by sector
	always_comb begin
		case (item.sector)
			SECTOR_1: begin
				k_c[0] = kq; k_c[1] = kv; k_c[2] = kp;
			end
			SECTOR_2: begin
				k_c[0] = kp; k_c[1] = kv; k_c[2] = kt;
			end
			SECTOR_3: begin
				k_c[0] = kp; k_c[1] = kq; k_c[2] = kv;
			end
			SECTOR_4: begin
				k_c[0] = kt; k_c[1] = kp; k_c[2] = kv;
			end
			SECTOR_5: begin
				k_c[0] = kv; k_c[1] = kp; k_c[2] = kq;
			end
			default: begin
				k_c[0] = kv; k_c[1] = kt; k_c[2] = kp;
			end
		endcase
	end

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			done_q <= vld_s3;
		end
	end

	// Scale by V, by 255, then divide by 2^18 and by 15, one lane per channel
	always_ff @(posedge clk) begin
		val_s1 <= item.val;
		for (int i = 0; i < 3; i++) begin
			k_s1[i]   <= k_c[i];
			m_s2[i]   <= 22'(val_s1) * 22'(k_s1[i]);
			y_s3[i]   <= 12'((30'(m_s2[i]) * 30'(CHAN_MAX)) >> CHAN_SHIFT);
			chan_q[i] <= 8'((25'(y_s3[i]) * 25'(DIV15_RECIP)) >> DIV15_SHIFT);
		end
	end

	assign done  = done_q;
	assign red   = chan_q[0];
	assign green = chan_q[1];
	assign blue  = chan_q[2];

endmodule

`default_nettype wire

// File: hdl/hsv_to_rgb_converter_top.sv
// HSV to RGB pixel converter. A request (hue in whole degrees, saturation and
// value in signed Q2.8 where 256 is 1.0) is taken on any clock edge with start
// high and busy low, one per cycle. The result appears on red, green and blue
// with done high for exactly one cycle; the receiver cannot stall it. A
// three-stage front wraps the hue, clamps saturation and value and finds the
// sector; a small queue feeds a four-stage back end that forms p, q and t and
// scales each channel by 255 with a truncating divide. The back end drains the
// queue every cycle, so busy stays low and the block sustains one pixel per
// clock.
`default_nettype none

module hsv_to_rgb_converter_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] hue_degrees,
	input  logic signed [9:0]  saturation,
	input  logic signed [9:0]  brightness,
	output logic               done,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);
	import hsvrgb_pkg::*;

	queue_status_t status;
	item_t         wr_item;
	item_t         rd_item;
	logic          push;
	logic          pop;

	hsvrgb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.hue_degrees (hue_degrees),
		.saturation  (saturation),
		.brightness  (brightness),
		.status      (status),
		.pop         (pop),
		.busy        (busy),
		.push        (push),
		.item        (wr_item)
	);

	hsvrgb_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.status  (status)
	);

	hsvrgb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.item   (rd_item),
		.pop    (pop),
		.done   (done),
		.red    (red),
		.green  (green),
		.blue   (blue)
	);

	// Every taken request comes out a fixed time later
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##8 done)
		else $error("request did not complete on time");

	// Every result traces back to a request leaving the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(pop, 4))
		else $error("result without a queued request");

	// Busy only while the queue is full
	assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> status.full)
		else $error("busy with room in the queue");

	// Queue cannot be full and empty together
	assert property (@(posedge clk) disable iff (!arst_n)
		!(status.full && status.empty))
		else $error("queue status inconsistent");

endmodule

`default_nettype wire
